/* src/ima_enc_pkg.sv */
// shared types, constants and tables for the adpcm encoder
// no dependencies; imported by every module of the block
package ima_enc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 7;
  localparam int STEP_W      = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam logic signed [17:0] PRED_MIN = -18'sd32768;
  localparam logic signed [17:0] PRED_MAX = 18'sd32767;

  localparam logic [BYTE_W-1:0] HI_MASK = 8'hf0;
  localparam logic [BYTE_W-1:0] LO_MASK = 8'h0f;

  // one accepted input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eob;
  } item_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_TABLE [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // step index adjustment by 3-bit magnitude
  function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

/* src/ima_enc_front.sv */
// input side: accepts samples into a short queue ahead of the encoder core
// depends on ima_enc_pkg
module ima_enc_front
  import ima_enc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_eob,
  output logic                       q_valid,
  output item_t                      q_item,
  input  logic                       q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign in_tready = (count_r != CNT_W'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{sample: in_sample, eob: in_eob};
    end
  end

endmodule

/* src/ima_enc_core.sv */
// back side: quantizer, predictor/index update, nibble packing, output register
// depends on ima_enc_pkg
module ima_enc_core
  import ima_enc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_code_byte,
  output logic              out_block_done
);

  logic signed [SAMPLE_W-1:0] pred_r, pred_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [CODE_W-1:0]          held_r, held_nxt;
  logic                       lnn_r, lnn_nxt;
  logic                       oval_r, oval_nxt;
  logic [BYTE_W-1:0]          obyte_r, obyte_nxt;
  logic                       olast_r, olast_nxt;

  logic [IDX_W-1:0]   idx_c;
  logic [STEP_W-1:0]  step0, step1, step2;
  logic signed [16:0] diff;
  logic [16:0]        mag0, mag1, mag2;
  logic [16:0]        change;
  logic [2:0]         mag;
  logic               sign;
  logic [CODE_W-1:0]  code;
  logic signed [7:0]  idx_sum;
  logic signed [17:0] pred_sum;
  logic               step_en;

  assign step_en = q_valid && (!oval_r || out_tready);
  assign q_pop   = step_en;

  // quantize one sample against the current step size
  always_comb begin
    idx_c  = (idx_r > IDX_MAX) ? IDX_MAX : idx_r;
    step0  = STEP_TABLE[idx_c];
    step1  = step0 >> 1;
    step2  = step0 >> 2;
    diff   = 17'(q_item.sample) - 17'(pred_r);
    sign   = diff[16];
    mag0   = sign ? 17'(-diff) : 17'(diff);
    change = 17'(step0 >> 3);
    mag    = '0;
    mag1   = mag0;
    if (mag0 >= 17'(step0)) begin
      mag[2] = 1'b1;
      mag1   = mag0 - 17'(step0);
      change = change + 17'(step0);
    end
    mag2 = mag1;
    if (mag1 >= 17'(step1)) begin
      mag[1] = 1'b1;
      mag2   = mag1 - 17'(step1);
      change = change + 17'(step1);
    end
    if (mag2 >= 17'(step2)) begin
      mag[0] = 1'b1;
      change = change + 17'(step2);
    end
    code     = {sign, mag};
    idx_sum  = $signed({1'b0, idx_c}) + 8'(idx_adjust(mag));
    pred_sum = sign ? (18'(pred_r) - $signed({1'b0, change}))
                    : (18'(pred_r) + $signed({1'b0, change}));
  end

  always_comb begin
    pred_nxt  = pred_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    lnn_nxt   = lnn_r;
    oval_nxt  = oval_r && !out_tready;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (step_en) begin
      if (idx_sum < 0) begin
        idx_nxt = '0;
      end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
        idx_nxt = IDX_MAX;
      end else begin
        idx_nxt = idx_sum[IDX_W-1:0];
      end
      if (pred_sum < PRED_MIN) begin
        pred_nxt = PRED_MIN[SAMPLE_W-1:0];
      end else if (pred_sum > PRED_MAX) begin
        pred_nxt = PRED_MAX[SAMPLE_W-1:0];
      end else begin
        pred_nxt = pred_sum[SAMPLE_W-1:0];
      end
      if (lnn_r) begin
        oval_nxt  = 1'b1;
        obyte_nxt = (({held_r, 4'b0000}) & HI_MASK) | ({4'b0000, code} & LO_MASK);
        olast_nxt = q_item.eob;
        lnn_nxt   = 1'b0;
      end else begin
        held_nxt = code;
        if (q_item.eob) begin
          oval_nxt  = 1'b1;
          obyte_nxt = {code, 4'b0000} & HI_MASK;
          olast_nxt = 1'b1;
        end else begin
          lnn_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_r <= '0;
      idx_r  <= '0;
      lnn_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      pred_r <= pred_nxt;
      idx_r  <= idx_nxt;
      lnn_r  <= lnn_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid     = oval_r;
  assign out_code_byte  = obyte_r;
  assign out_block_done = olast_r;

endmodule

/* src/ima_adpcm_encoder_unit.sv */
// top level of the 4-bit ima/dvi adpcm encoder with nibble packing
// depends on ima_enc_pkg, ima_enc_front, ima_enc_core
//
// takes one signed 16-bit pcm sample per transaction and returns packed
// 4-bit adpcm codes, two per byte with the first code in the high nibble.
// a sample with in_tlast set ends a block: a pending pair goes out whole,
// a lone code goes out with a zero low nibble, and out_tlast marks that
// byte. throughput is one sample per clock unless the output stalls;
// the rate is set by the predictor/step-index update in the core, which
// every sample passes through in turn. with an empty queue a sample goes
// through a queue slot, then the output register. the QUEUE_DEPTH_P-entry
// input queue keeps accepting samples while the output is stalled, until full.
module ima_adpcm_encoder_unit
  import ima_enc_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] sample_in (signed)
  input  logic        in_tlast,    // end_of_block
  // code output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] code_byte
  output logic        out_tlast    // block_done
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // front: accept and queue samples
  ima_enc_front #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_sample ($signed(in_tdata)),
    .in_eob    (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: encode, pack, hold result until taken
  ima_enc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_code_byte  (out_tdata),
    .out_block_done (out_tlast)
  );

endmodule
